// ----- sv/oukl_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered unique key list: shared definitions
// Field widths, operation codes and status codes used across the design.
// ----------------------------------------------------------------------------
package oukl_pkg;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 3;
    localparam int POS_BITS    = 4;
    localparam int VALUE_BITS  = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD     = 3'd0,
        OP_DELETE  = 3'd1,
        OP_INSERT  = 3'd2,
        OP_SEARCH  = 3'd3,
        OP_UPDATE  = 3'd4,
        OP_DISPLAY = 3'd5
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_INVALID  = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

endpackage

// ----- sv/oukl_in_if.sv -----
// ----------------------------------------------------------------------------
// Ordered unique key list: request channel
// Valid/ready channel carrying one operation request per word.
// ----------------------------------------------------------------------------
interface oukl_in_if
    import oukl_pkg::*;
#(
    parameter int KEY_BITS = 32
);
    logic                valid;
    logic                ready;
    logic [OP_BITS-1:0]  operation;
    logic [KEY_BITS-1:0] key;
    logic [KEY_BITS-1:0] second_key;

    modport source (output valid, operation, key, second_key, input ready);
    modport sink   (input valid, operation, key, second_key, output ready);
endinterface

// ----- sv/oukl_out_if.sv -----
// ----------------------------------------------------------------------------
// Ordered unique key list: result channel
// Valid/ready channel carrying one result word per handshake.
// ----------------------------------------------------------------------------
interface oukl_out_if
    import oukl_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [POS_BITS-1:0]    position;
    logic [VALUE_BITS-1:0]  value;
    logic                   last;

    modport source (output valid, status, position, value, last, input ready);
    modport sink   (input valid, status, position, value, last, output ready);
endinterface

// ----- sv/oukl_cell.sv -----
// ----------------------------------------------------------------------------
// Ordered unique key list: slot cell
// One slot of the key ring. On a shift it takes the key of its neighbor.
// ----------------------------------------------------------------------------
module oukl_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [KEY_BITS-1:0] i_key,
    output logic [KEY_BITS-1:0] o_key
);
    logic [KEY_BITS-1:0] r_key;

    // The store is cleared at reset; zero marks an empty slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_shift) begin
            r_key <= i_key;
        end
    end

    assign o_key = r_key;
endmodule

// ----- sv/oukl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Ordered unique key list: controller
// Watches the head of the ring during a scan pass, decides the operation,
// then rewrites the ring or streams it out in a second pass.
// ----------------------------------------------------------------------------
module oukl_ctrl
    import oukl_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    oukl_in_if.sink             i_in,
    oukl_out_if.source          o_out,
    input  logic [KEY_BITS-1:0] i_head,
    output logic                o_shift,
    output logic [KEY_BITS-1:0] o_tail
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CNT_LAST  = CW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MODIFY,
        S_DISPLAY
    } t_state;

    typedef enum logic [1:0] {
        MOD_WRITE,
        MOD_DELETE,
        MOD_INSERT
    } t_mod;

    t_state              r_state;
    logic [OP_BITS-1:0]  r_op;
    logic [KEY_BITS-1:0] r_k1;
    logic [KEY_BITS-1:0] r_k2;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_end;
    logic [IW-1:0]       r_e;
    logic [IW-1:0]       r_a;
    logic [IW-1:0]       r_b;
    logic                r_fe;
    logic                r_fa;
    logic                r_fb;
    t_mod                r_mod;
    logic [IW-1:0]       r_pos;
    logic [KEY_BITS-1:0] r_wkey;
    logic [KEY_BITS-1:0] r_prev;

    logic                   r_ov;
    t_status                r_status;
    logic [POS_BITS-1:0]    r_position;
    logic [VALUE_BITS-1:0]  r_value;
    logic                   r_last;

    logic                out_free;
    logic [IW-1:0]       scan_idx;
    logic [CW-1:0]       cpos;

    logic                dec_emit;
    t_status             dec_status;
    logic [IW-1:0]       dec_pos;
    logic                dec_modify;
    logic                dec_display;
    t_mod                dec_mod;
    logic [KEY_BITS-1:0] dec_wkey;
    logic                k1_zero;
    logic                k2_zero;

    assign out_free = !r_ov || o_out.ready;
    assign scan_idx = r_cnt[IW-1:0];
    assign cpos     = CW'(r_pos);
    assign k1_zero  = (r_k1 == '0);
    assign k2_zero  = (r_k2 == '0);

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.status   = r_status;
    assign o_out.position = r_position;
    assign o_out.value    = r_value;
    assign o_out.last     = r_last;

    // Outcome of the operation once the scan has located the first empty
    // slot and the slots of both keys.
    always_comb begin
        dec_emit    = 1'b1;
        dec_status  = ST_OK;
        dec_pos     = '0;
        dec_modify  = 1'b0;
        dec_display = 1'b0;
        dec_mod     = MOD_WRITE;
        dec_wkey    = r_k1;
        case (t_op'(r_op))
            OP_ADD: begin
                if (k1_zero) begin
                    dec_status = ST_INVALID;
                end else if (!r_fe) begin
                    dec_status = ST_FULL;
                end else if (r_fa) begin
                    dec_status = ST_DUP;
                end else begin
                    dec_pos    = r_e;
                    dec_modify = 1'b1;
                end
            end
            OP_DELETE: begin
                if (k1_zero) begin
                    dec_status = ST_INVALID;
                end else if (!r_fa) begin
                    dec_status = ST_NOTFOUND;
                end else begin
                    dec_pos    = r_a;
                    dec_modify = 1'b1;
                    dec_mod    = MOD_DELETE;
                end
            end
            OP_INSERT: begin
                if (k1_zero || k2_zero) begin
                    dec_status = ST_INVALID;
                end else if (!r_fe) begin
                    dec_status = ST_FULL;
                end else if (r_fa) begin
                    dec_status = ST_DUP;
                end else if (!r_fb) begin
                    dec_status = ST_NOTFOUND;
                end else begin
                    dec_pos    = r_b;
                    dec_modify = 1'b1;
                    dec_mod    = MOD_INSERT;
                end
            end
            OP_SEARCH: begin
                if (k1_zero) begin
                    dec_status = ST_INVALID;
                end else if (!r_fa) begin
                    dec_status = ST_NOTFOUND;
                end else begin
                    dec_pos = r_a;
                end
            end
            OP_UPDATE: begin
                if (k1_zero || k2_zero) begin
                    dec_status = ST_INVALID;
                end else if (!r_fa) begin
                    dec_status = ST_NOTFOUND;
                end else if (r_fb) begin
                    dec_status = ST_DUP;
                end else begin
                    dec_pos    = r_a;
                    dec_modify = 1'b1;
                    dec_wkey   = r_k2;
                end
            end
            OP_DISPLAY: begin
                if (r_fe && (r_e == '0)) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_emit    = 1'b0;
                    dec_display = 1'b1;
                end
            end
            default: begin
                dec_emit = 1'b0;
            end
        endcase
    end

    // Ring feed. A rewrite pass sees the old slot i at the head in step i.
    // Delete runs on into step DEPTH so that each slot can take its upper
    // neighbor, which then appears at the head in the following step.
    always_comb begin
        o_shift = 1'b0;
        o_tail  = i_head;
        case (r_state)
            S_SCAN: begin
                o_shift = 1'b1;
            end
            S_DISPLAY: begin
                o_shift = out_free;
            end
            S_MODIFY: begin
                o_shift = 1'b1;
                if (r_mod == MOD_DELETE) begin
                    if (r_cnt == '0) begin
                        o_tail = i_head;
                    end else if (r_cnt <= cpos) begin
                        o_tail = r_prev;
                    end else if (r_cnt == CNT_DEPTH) begin
                        o_tail = '0;
                    end else begin
                        o_tail = i_head;
                    end
                end else if (r_cnt == cpos) begin
                    o_tail = r_wkey;
                end else if ((r_mod == MOD_INSERT) && (r_cnt > cpos)) begin
                    o_tail = r_prev;
                end else begin
                    o_tail = i_head;
                end
            end
            default: begin
                o_shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_fe    <= 1'b0;
            r_fa    <= 1'b0;
            r_fb    <= 1'b0;
        end else begin
            if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op    <= i_in.operation;
                        r_k1    <= i_in.key;
                        r_k2    <= i_in.second_key;
                        r_fe    <= 1'b0;
                        r_fa    <= 1'b0;
                        r_fb    <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_fe && (i_head == '0)) begin
                        r_fe <= 1'b1;
                        r_e  <= scan_idx;
                    end
                    if (!r_fa && (i_head == r_k1)) begin
                        r_fa <= 1'b1;
                        r_a  <= scan_idx;
                    end
                    if (!r_fb && (i_head == r_k2)) begin
                        r_fb <= 1'b1;
                        r_b  <= scan_idx;
                    end
                    if (r_cnt == CNT_LAST) begin
                        r_cnt   <= '0;
                        r_state <= S_DECIDE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (out_free) begin
                        if (dec_emit) begin
                            r_ov       <= 1'b1;
                            r_status   <= dec_status;
                            r_position <= POS_BITS'(dec_pos);
                            r_value    <= '0;
                            r_last     <= 1'b1;
                        end
                        r_pos  <= dec_pos;
                        r_mod  <= dec_mod;
                        r_wkey <= dec_wkey;
                        r_end  <= r_fe ? CW'(r_e) : CNT_DEPTH;
                        if (dec_modify) begin
                            r_state <= S_MODIFY;
                        end else if (dec_display) begin
                            r_state <= S_DISPLAY;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MODIFY: begin
                    r_prev <= i_head;
                    if (r_cnt == ((r_mod == MOD_DELETE) ? CNT_DEPTH : CNT_LAST)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DISPLAY: begin
                    if (out_free) begin
                        // Occupied slots form a packed prefix of r_end slots.
                        if (r_cnt < r_end) begin
                            r_ov       <= 1'b1;
                            r_status   <= ST_OK;
                            r_position <= POS_BITS'(r_cnt);
                            r_value    <= VALUE_BITS'(i_head);
                            r_last     <= (r_cnt == (r_end - 1'b1));
                        end
                        if (r_cnt == CNT_LAST) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- sv/ordered_unique_key_list.sv -----
// ----------------------------------------------------------------------------
// Ordered unique key list
// Keeps up to DEPTH unique nonzero keys in a ring of slot cells and serves
// add, delete, insert before, search, update and display requests.
// ----------------------------------------------------------------------------
// The keys live in a ring of DEPTH cells. During a pass it rotates one slot per
// clock, unless a display pass is held by the result register, past a single
// compare point at its head, so each request costs whole ring turns.
// Every request first takes a scan turn and then a decision step. Search and
// every rejected request end there with one result word, an undefined
// operation code with none. A successful add, insert, update or delete then
// rewrites the ring in a further pass. Display streams one word per occupied
// slot during a further turn, pausing while the result register is not taken.
// The decision step likewise waits while an earlier result word is still
// held. A new request is taken only once the previous one has finished its
// passes; its last result word may still be waiting.
// The slots are cleared by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_unique_key_list #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oukl_in_if.sink    i_in,
    oukl_out_if.source o_out
);
    logic [KEY_BITS-1:0] ring_key [DEPTH];
    logic [KEY_BITS-1:0] tail_key;
    logic                ring_shift;

    // Cell 0 is the head; each cell takes its upper neighbor on a shift.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_top
            oukl_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (ring_shift),
                .i_key   (tail_key),
                .o_key   (ring_key[g])
            );
        end else begin : g_mid
            oukl_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (ring_shift),
                .i_key   (ring_key[g+1]),
                .o_key   (ring_key[g])
            );
        end
    end

    oukl_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_head  (ring_key[0]),
        .o_shift (ring_shift),
        .o_tail  (tail_key)
    );
endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Ordered unique key list testbench
// Drives add, delete, insert, search, update and display requests with random
// gaps on both channels, tracks the slot contents alongside the block and
// checks every result word, in order, against the predicted words.
// ----------------------------------------------------------------------------
module tb_top
    import oukl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 32;

    // Operation codes the block leaves undefined; they must be ignored.
    localparam logic [OP_BITS-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct {
        t_status               status;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    oukl_in_if #(.KEY_BITS(KEY_BITS)) in_if ();
    oukl_out_if                       out_if ();

    ordered_unique_key_list #(
        .DEPTH   (DEPTH),
        .KEY_BITS(KEY_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    logic [KEY_BITS-1:0] list_slots [DEPTH];
    t_list_result        pending_results [$];
    int unsigned         fail_count;
    bit                  send_calm;
    bit                  recv_calm;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL ordered_unique_key_list");
        $finish;
    end

    function automatic int unsigned draw_gap(bit calm);
        if (calm || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic void note_failure(string msg);
        if (fail_count < 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        fail_count++;
    endfunction

    // ---------------------------------------------------------------- model

    function automatic int slot_of(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < DEPTH; i++) begin
            if (list_slots[i] == k) begin
                return i;
            end
        end
        return DEPTH;
    endfunction

    function automatic int occupied_count();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (list_slots[i] != '0) begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic void queue_result(t_status st, int pos, logic [KEY_BITS-1:0] val,
                                         logic last);
        t_list_result w;
        w.status   = st;
        w.position = pos[POS_BITS-1:0];
        w.value    = val[VALUE_BITS-1:0];
        w.last     = last;
        pending_results.push_back(w);
    endfunction

    function automatic void predict_list_op(logic [OP_BITS-1:0] op,
                                            logic [KEY_BITS-1:0] k1,
                                            logic [KEY_BITS-1:0] k2);
        int hit;
        int hole;
        int total;
        int shown;
        case (op)
            OP_ADD: begin
                hole = slot_of('0);
                if (k1 == '0) begin
                    queue_result(ST_INVALID, 0, '0, 1'b1);
                end else if (hole == DEPTH) begin
                    queue_result(ST_FULL, 0, '0, 1'b1);
                end else if (slot_of(k1) < DEPTH) begin
                    queue_result(ST_DUP, 0, '0, 1'b1);
                end else begin
                    list_slots[hole] = k1;
                    queue_result(ST_OK, hole, '0, 1'b1);
                end
            end
            OP_DELETE: begin
                hit = slot_of(k1);
                if (k1 == '0) begin
                    queue_result(ST_INVALID, 0, '0, 1'b1);
                end else if (hit == DEPTH) begin
                    queue_result(ST_NOTFOUND, 0, '0, 1'b1);
                end else begin
                    for (int i = hit; i < DEPTH - 1; i++) begin
                        list_slots[i] = list_slots[i + 1];
                    end
                    list_slots[DEPTH - 1] = '0;
                    queue_result(ST_OK, hit, '0, 1'b1);
                end
            end
            OP_INSERT: begin
                hit = slot_of(k2);
                if (k1 == '0 || k2 == '0) begin
                    queue_result(ST_INVALID, 0, '0, 1'b1);
                end else if (slot_of('0) == DEPTH) begin
                    queue_result(ST_FULL, 0, '0, 1'b1);
                end else if (slot_of(k1) < DEPTH) begin
                    queue_result(ST_DUP, 0, '0, 1'b1);
                end else if (hit == DEPTH) begin
                    queue_result(ST_NOTFOUND, 0, '0, 1'b1);
                end else begin
                    for (int i = DEPTH - 1; i > hit; i--) begin
                        list_slots[i] = list_slots[i - 1];
                    end
                    list_slots[hit] = k1;
                    queue_result(ST_OK, hit, '0, 1'b1);
                end
            end
            OP_SEARCH: begin
                hit = slot_of(k1);
                if (k1 == '0) begin
                    queue_result(ST_INVALID, 0, '0, 1'b1);
                end else if (hit == DEPTH) begin
                    queue_result(ST_NOTFOUND, 0, '0, 1'b1);
                end else begin
                    queue_result(ST_OK, hit, '0, 1'b1);
                end
            end
            OP_UPDATE: begin
                hit = slot_of(k1);
                if (k1 == '0 || k2 == '0) begin
                    queue_result(ST_INVALID, 0, '0, 1'b1);
                end else if (hit == DEPTH) begin
                    queue_result(ST_NOTFOUND, 0, '0, 1'b1);
                end else if (slot_of(k2) < DEPTH) begin
                    queue_result(ST_DUP, 0, '0, 1'b1);
                end else begin
                    list_slots[hit] = k2;
                    queue_result(ST_OK, hit, '0, 1'b1);
                end
            end
            OP_DISPLAY: begin
                total = occupied_count();
                shown = 0;
                if (total == 0) begin
                    queue_result(ST_EMPTY, 0, '0, 1'b1);
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (list_slots[i] != '0) begin
                        shown++;
                        queue_result(ST_OK, i, list_slots[i], shown == total);
                    end
                end
            end
            default: begin
                // Undefined codes leave the list alone and give no word.
            end
        endcase
    endfunction

    // ---------------------------------------------------------- key choice

    function automatic logic [KEY_BITS-1:0] fresh_key();
        logic [KEY_BITS-1:0] k;
        do begin
            k = $urandom;
        end while (k == '0 || slot_of(k) < DEPTH);
        return k;
    endfunction

    // The occupied slots form a packed prefix, so any index below the count holds a key.
    function automatic logic [KEY_BITS-1:0] present_key();
        return list_slots[$urandom_range(0, occupied_count() - 1)];
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key(int unsigned present_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            return '0;
        end
        if (r < 6 + present_pct && occupied_count() > 0) begin
            return present_key();
        end
        return fresh_key();
    endfunction

    // ------------------------------------------------------------- drivers

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_request(input logic [OP_BITS-1:0]  op,
                                input logic [KEY_BITS-1:0] k1,
                                input logic [KEY_BITS-1:0] k2);
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.operation  <= op;
        in_if.key        <= k1;
        in_if.second_key <= k2;
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        predict_list_op(op, k1, k2);
    endtask

    initial begin : result_checker
        int unsigned  stall;
        t_list_result want;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_gap(recv_calm);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (out_if.valid !== 1'b1 || out_if.ready !== 1'b1);
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected word status=%0d pos=%0d value=%h last=%b",
                    out_if.status, out_if.position, out_if.value, out_if.last));
            end else begin
                want = pending_results.pop_front();
                if (out_if.status !== want.status || out_if.position !== want.position ||
                    out_if.value !== want.value || out_if.last !== want.last) begin
                    note_failure($sformatf(
                        "expected status=%0d pos=%0d value=%h last=%b, got %0d %0d %h %b",
                        want.status, want.position, want.value, want.last,
                        out_if.status, out_if.position, out_if.value, out_if.last));
                end
            end
        end
    end

    // --------------------------------------------------------------- tests

    task automatic test_empty_list();
        send_request(OP_DISPLAY, '0, '0);
        send_request(OP_SEARCH, '0, 32'h1234_5678);
        send_request(OP_DELETE, 32'h0000_0042, '0);
        send_request(OP_INSERT, 32'h0000_0011, 32'h0000_0022);
        send_request(OP_UNDEF_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_UNDEF_HI, 32'h0000_0001, 32'h0000_0001);
    endtask

    task automatic test_key_extremes();
        send_request(OP_ADD, '0, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'hFFFF_FFFF, '0);
        send_request(OP_ADD, 32'h0000_0001, '0);
        send_request(OP_ADD, 32'h0000_0001, '0);
        send_request(OP_INSERT, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_INSERT, 32'h0000_0005, '0);
        send_request(OP_UPDATE, 32'h0000_0001, 32'h0000_0001);
        send_request(OP_UPDATE, 32'h0000_0001, 32'h7FFF_FFFF);
        send_request(OP_SEARCH, 32'h7FFF_FFFF, '0);
        send_request(OP_DELETE, 32'hFFFF_FFFF, '0);
        send_request(OP_DISPLAY, '0, '0);
    endtask

    // Fill the list to capacity, exercise the full cases, then empty it again.
    task automatic test_fill_and_drain();
        while (occupied_count() < DEPTH) begin
            send_request(OP_ADD, fresh_key(), $urandom);
        end
        send_request(OP_ADD, fresh_key(), '0);
        send_request(OP_ADD, present_key(), '0);
        send_request(OP_INSERT, fresh_key(), present_key());
        send_request(OP_INSERT, '0, present_key());
        send_request(OP_UPDATE, present_key(), fresh_key());
        send_request(OP_SEARCH, list_slots[DEPTH - 1], '0);
        send_request(OP_DISPLAY, $urandom, $urandom);
        send_request(OP_DELETE, list_slots[DEPTH - 1], '0);
        send_request(OP_INSERT, fresh_key(), list_slots[0]);
        send_request(OP_DISPLAY, '0, '0);
        send_request(OP_DELETE, list_slots[0], '0);
        while (occupied_count() > 0) begin
            send_request(OP_DELETE, present_key(), $urandom);
        end
        send_request(OP_DISPLAY, '0, '0);
    endtask

    task automatic test_random_mix(int unsigned count);
        bit                  grow;
        int unsigned         r;
        int unsigned         add_w;
        int unsigned         del_w;
        logic [OP_BITS-1:0]  op;
        logic [KEY_BITS-1:0] k1;
        logic [KEY_BITS-1:0] k2;
        grow = 1'b0;
        for (int n = 0; n < count; n++) begin
            if (n % 30 == 0) begin
                grow      = ~grow;
                send_calm = ($urandom_range(0, 3) == 0);
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            add_w = grow ? 30 : 10;
            del_w = grow ? 10 : 40;
            r = $urandom_range(0, 99);
            if (r < add_w) begin
                op = OP_ADD;
            end else if (r < add_w + 18) begin
                op = OP_INSERT;
            end else if (r < add_w + 18 + del_w) begin
                op = OP_DELETE;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    op = OP_SEARCH;
                end else if (r < 62) begin
                    op = OP_UPDATE;
                end else if (r < 88) begin
                    op = OP_DISPLAY;
                end else begin
                    op = r[0] ? OP_UNDEF_HI : OP_UNDEF_LO;
                end
            end
            k1 = $urandom;
            k2 = $urandom;
            case (op)
                OP_ADD:    k1 = pick_key(20);
                OP_DELETE: k1 = pick_key(80);
                OP_SEARCH: k1 = pick_key(70);
                OP_INSERT: begin
                    k1 = pick_key(15);
                    k2 = pick_key(80);
                end
                OP_UPDATE: begin
                    k1 = pick_key(80);
                    k2 = pick_key(20);
                end
                default: begin
                end
            endcase
            send_request(op, k1, k2);
        end
    endtask

    initial begin
        fail_count          = 0;
        send_calm           = 1'b0;
        recv_calm           = 1'b0;
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.operation     = OP_ADD;
        in_if.key           = '0;
        in_if.second_key    = '0;
        for (int i = 0; i < DEPTH; i++) begin
            list_slots[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_key_extremes();
        test_fill_and_drain();
        test_random_mix(200);

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // A request that yields nothing can still be busy; give it time to misbehave.
        repeat (100) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d words never arrived", pending_results.size()));
        end
        if (fail_count == 0) begin
            $display("PASS ordered_unique_key_list");
        end else begin
            $display("FAIL ordered_unique_key_list");
        end
        $finish;
    end

endmodule

// ----- ordered_unique_key_list.f -----
sv/oukl_pkg.sv
sv/oukl_in_if.sv
sv/oukl_out_if.sv
sv/oukl_cell.sv
sv/oukl_ctrl.sv
sv/ordered_unique_key_list.sv
sim/tb_top.sv
